// ===== design/kpi_pkg.sv =====
// ----------------------------------------------------------------------------
// kpi_pkg
// Types and constants shared by the keyframe pose interpolator modules.
// ----------------------------------------------------------------------------
package kpi_pkg;

   localparam int MAX_FRAMES = 8;
   localparam int NUM_ANIMS  = 16;
   localparam int NUM_PARTS  = 4;
   localparam int SEQ_DEPTH  = NUM_ANIMS * NUM_PARTS;
   localparam int KF_DEPTH   = SEQ_DEPTH * MAX_FRAMES;
   localparam int SEQ_AW     = $clog2(SEQ_DEPTH);
   localparam int KF_AW      = $clog2(KF_DEPTH);
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_SET  = 2'd1;
   localparam logic [1:0] MODE_ADD  = 2'd2;

   typedef struct packed {
      logic [1:0]         mode;
      logic [3:0]         anim_index;
      logic [1:0]         part_index;
      logic [2:0]         frame_index;
      logic [3:0]         frame_count;
      logic [15:0]        key_time;
      logic signed [15:0] key_x;
      logic signed [15:0] key_y;
      logic signed [15:0] key_angle;
      logic [15:0]        eval_time;
      logic signed [15:0] amount;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         out_part;
      logic [15:0]        pose_time;
      logic signed [15:0] pose_x;
      logic signed [15:0] pose_y;
      logic signed [15:0] pose_angle;
      logic               last_part;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0]        t;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] a;
   } kf_type;

   // decoded command passed from front to back
   typedef struct packed {
      logic        is_load;
      logic        is_add;
      logic        anim_ok;
      logic        frame_ok;
      logic [3:0]  anim;
      logic [1:0]  part;
      logic [2:0]  frame;
      logic [3:0]  count;
      kf_type      key;
      logic [15:0] eval_time;
      logic signed [15:0] amount;
   } cmd_type;

   // queue control driven by the front
   typedef struct packed {
      logic full;
      logic push;
   } q_ctl_type;

endpackage

// ===== design/kpi_front.sv =====
// ----------------------------------------------------------------------------
// kpi_front
// Accepts request items, drops unused modes, clamps and range-checks fields.
// ----------------------------------------------------------------------------
module kpi_front (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kpi_pkg::req_item_type req_data,
   input  logic                  q_full,
   output kpi_pkg::q_ctl_type    q_ctl,
   output kpi_pkg::cmd_type      q_data
);
   import kpi_pkg::*;

   logic mode_used;

   assign mode_used = (req_data.mode == MODE_LOAD) || (req_data.mode == MODE_SET) ||
                      (req_data.mode == MODE_ADD);
   assign req_ready  = !q_full;
   assign q_ctl.full = q_full;
   assign q_ctl.push = req_valid && !q_full && mode_used;

   always_comb begin
      q_data.is_load  = (req_data.mode == MODE_LOAD);
      q_data.is_add   = (req_data.mode == MODE_ADD);
      q_data.anim_ok  = (32'(req_data.anim_index) < NUM_ANIMS);
      q_data.frame_ok = (32'(req_data.frame_index) < MAX_FRAMES);
      q_data.anim     = req_data.anim_index;
      q_data.part     = req_data.part_index;
      q_data.frame    = req_data.frame_index;
      if (32'(req_data.frame_count) > MAX_FRAMES) begin
         q_data.count = 4'(MAX_FRAMES);
      end else begin
         q_data.count = req_data.frame_count;
      end
      q_data.key.t     = req_data.key_time;
      q_data.key.x     = req_data.key_x;
      q_data.key.y     = req_data.key_y;
      q_data.key.a     = req_data.key_angle;
      q_data.eval_time = req_data.eval_time;
      q_data.amount    = req_data.amount;
   end

endmodule

// ===== design/kpi_queue.sv =====
// ----------------------------------------------------------------------------
// kpi_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module kpi_queue (
   input  logic               clock,
   input  logic               reset,
   input  kpi_pkg::q_ctl_type q_ctl,
   input  kpi_pkg::cmd_type   push_data,
   output logic               full,
   output logic               pop_valid,
   input  logic               pop,
   output kpi_pkg::cmd_type   pop_data
);
   import kpi_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   fill_ff, fill_in;

   assign full      = (32'(fill_ff) == QUEUE_DEPTH);
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (q_ctl.push) begin
         wr_in = (32'(wr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ff + 1'b1;
      end
      if (pop && pop_valid) begin
         rd_in = (32'(rd_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ff + 1'b1;
      end
      if (q_ctl.push && !(pop && pop_valid)) begin
         fill_in = fill_ff + 1'b1;
      end else if (!q_ctl.push && pop && pop_valid) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_ctl.push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== design/kpi_back.sv =====
// ----------------------------------------------------------------------------
// kpi_back
// Executes commands: keyframe loads, per-part scan, blend divide, pose update.
// ----------------------------------------------------------------------------
module kpi_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_pop,
   input  kpi_pkg::cmd_type      cmd_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kpi_pkg::rsp_item_type rsp_data
);
   import kpi_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CNT   = 4'd1;
   localparam logic [3:0] S_CNTW  = 4'd2;
   localparam logic [3:0] S_RD    = 4'd3;
   localparam logic [3:0] S_CHK   = 4'd4;
   localparam logic [3:0] S_MUL   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_FIN   = 4'd7;
   localparam logic [3:0] S_APPLY = 4'd8;
   localparam logic [3:0] S_SUM   = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;

   // memories
   kf_type     kf_mem  [KF_DEPTH];
   logic [3:0] cnt_mem [SEQ_DEPTH];
   logic [SEQ_DEPTH-1:0] cnt_vld_ff;
   kf_type     kf_rd_ff;
   logic [3:0] cnt_rd_ff;
   logic       cvld_rd_ff;

   logic [3:0]  state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [1:0]  part_ff, part_in;
   logic [2:0]  fr_ff, fr_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        single_ff, single_in;
   kf_type      prev_ff, prev_in;
   logic [15:0] span_ff, span_in;
   logic [15:0] d_ff, d_in;
   logic [3:0]  step_ff, step_in;
   logic [2:0]       neg_ff, neg_in;
   logic [2:0][15:0] base_ff, base_in;
   logic [2:0][15:0] mag_ff, mag_in;
   logic [2:0][15:0] rem_ff, rem_in;
   logic [2:0][15:0] quo_ff, quo_in;
   logic [2:0][31:0] sprod_ff, sprod_in;
   kf_type      val_ff, val_in;
   logic        ok_ff, ok_in;
   kf_type      pose_ff [NUM_PARTS];
   kf_type      pose_wr;
   logic        pose_we;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   logic [SEQ_AW-1:0] seq_addr;
   logic [KF_AW-1:0]  kf_addr;
   logic              load_now;
   logic [3:0]        cnt_eff;

   // combinational scratch
   logic [2:0][15:0] fa, fb;
   logic signed [16:0] diff;
   logic [31:0]      num;
   logic [16:0]      sh;
   logic [15:0]      q;
   logic [16:0]      blend;
   logic signed [32:0] rnd;
   logic signed [18:0] sum;
   logic [2:0][15:0] pose_c;
   logic [2:0][15:0] val_c;
   logic [2:0][15:0] sum_c;

   assign load_now = (state_ff == S_IDLE) && cmd_valid && cmd_data.is_load;
   assign cmd_pop  = (state_ff == S_IDLE) && cmd_valid;
   assign cnt_eff  = (cvld_rd_ff && cmd_ff.anim_ok) ? cnt_rd_ff : 4'd0;

   always_comb begin
      if (load_now) begin
         seq_addr = SEQ_AW'(32'(cmd_data.anim) * NUM_PARTS + 32'(cmd_data.part));
         kf_addr  = KF_AW'((32'(cmd_data.anim) * NUM_PARTS + 32'(cmd_data.part))
                           * MAX_FRAMES + 32'(cmd_data.frame));
      end else begin
         seq_addr = SEQ_AW'(32'(cmd_ff.anim) * NUM_PARTS + 32'(part_ff));
         kf_addr  = KF_AW'((32'(cmd_ff.anim) * NUM_PARTS + 32'(part_ff))
                           * MAX_FRAMES + 32'(fr_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (load_now && cmd_data.anim_ok && cmd_data.frame_ok) begin
         kf_mem[kf_addr] <= cmd_data.key;
      end
      if (load_now && cmd_data.anim_ok) begin
         cnt_mem[seq_addr] <= cmd_data.count;
      end
      kf_rd_ff   <= kf_mem[kf_addr];
      cnt_rd_ff  <= cnt_mem[seq_addr];
      cvld_rd_ff <= cnt_vld_ff[seq_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (load_now && cmd_data.anim_ok) begin
         cnt_vld_ff[seq_addr] <= 1'b1;
      end
   end

   assign pose_c[0] = pose_ff[part_ff].x;
   assign pose_c[1] = pose_ff[part_ff].y;
   assign pose_c[2] = pose_ff[part_ff].a;
   assign val_c[0]  = val_ff.x;
   assign val_c[1]  = val_ff.y;
   assign val_c[2]  = val_ff.a;
   assign fa[0] = prev_ff.x;
   assign fa[1] = prev_ff.y;
   assign fa[2] = prev_ff.a;
   assign fb[0] = kf_rd_ff.x;
   assign fb[1] = kf_rd_ff.y;
   assign fb[2] = kf_rd_ff.a;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      part_in      = part_ff;
      fr_in        = fr_ff;
      cnt_in       = cnt_ff;
      single_in    = single_ff;
      prev_in      = prev_ff;
      span_in      = span_ff;
      d_in         = d_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      base_in      = base_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      sprod_in     = sprod_ff;
      val_in       = val_ff;
      ok_in        = ok_ff;
      pose_we      = 1'b0;
      pose_wr      = pose_ff[part_ff];
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      diff  = '0;
      num   = '0;
      sh    = '0;
      q     = '0;
      blend = '0;
      rnd   = '0;
      sum   = '0;
      sum_c = '0;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in  = cmd_data;
               part_in = '0;
               if (!cmd_data.is_load) begin
                  state_in = S_CNT;
               end
            end
         end
         S_CNT: begin
            state_in = S_CNTW;
         end
         S_CNTW: begin
            cnt_in    = cnt_eff;
            fr_in     = '0;
            single_in = (cnt_eff == 4'd1);
            if (cnt_eff == 4'd0) begin
               val_in   = '0;
               ok_in    = 1'b1;
               state_in = S_APPLY;
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (single_ff) begin
               val_in   = kf_rd_ff;
               ok_in    = 1'b1;
               state_in = S_APPLY;
            end else if (fr_ff == '0) begin
               prev_in  = kf_rd_ff;
               fr_in    = 3'd1;
               state_in = S_RD;
            end else if (prev_ff.t <= cmd_ff.eval_time && kf_rd_ff.t >= cmd_ff.eval_time) begin
               span_in  = kf_rd_ff.t - prev_ff.t;
               d_in     = cmd_ff.eval_time - prev_ff.t;
               ok_in    = 1'b1;
               val_in   = prev_ff;
               val_in.t = cmd_ff.eval_time;
               for (int c = 0; c < 3; c++) begin
                  diff       = $signed({fb[c][15], fb[c]}) - $signed({fa[c][15], fa[c]});
                  neg_in[c]  = diff[16];
                  mag_in[c]  = diff[16] ? 16'(-diff) : diff[15:0];
                  base_in[c] = fa[c];
               end
               // zero-length segment keeps the earlier keyframe
               state_in = (kf_rd_ff.t == prev_ff.t) ? S_APPLY : S_MUL;
            end else if ({1'b0, fr_ff} == cnt_ff - 4'd1) begin
               ok_in    = 1'b0;
               state_in = S_APPLY;
            end else begin
               prev_in  = kf_rd_ff;
               fr_in    = fr_ff + 3'd1;
               state_in = S_RD;
            end
         end
         S_MUL: begin
            // quotient never exceeds the magnitude, so 16 steps suffice
            for (int c = 0; c < 3; c++) begin
               num       = mag_ff[c] * d_ff + 32'(span_ff >> 1);
               rem_in[c] = num[31:16];
               quo_in[c] = num[15:0];
            end
            step_in  = 4'd15;
            state_in = S_DIV;
         end
         S_DIV: begin
            for (int c = 0; c < 3; c++) begin
               sh = {rem_ff[c], quo_ff[c][15]};
               if (sh >= {1'b0, span_ff}) begin
                  rem_in[c] = 16'(sh - {1'b0, span_ff});
                  quo_in[c] = {quo_ff[c][14:0], 1'b1};
               end else begin
                  rem_in[c] = sh[15:0];
                  quo_in[c] = {quo_ff[c][14:0], 1'b0};
               end
            end
            step_in = step_ff - 4'd1;
            if (step_ff == 4'd0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            for (int c = 0; c < 3; c++) begin
               q = quo_ff[c];
               if (neg_ff[c]) begin
                  blend = {1'b0, base_ff[c]} - {1'b0, q};
               end else begin
                  blend = {1'b0, base_ff[c]} + {1'b0, q};
               end
               sum_c[c] = blend[15:0];
            end
            val_in.x = sum_c[0];
            val_in.y = sum_c[1];
            val_in.a = sum_c[2];
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (!cmd_ff.is_add) begin
               if (ok_ff) begin
                  pose_we = 1'b1;
                  pose_wr = val_ff;
               end
               state_in = S_OUT;
            end else if (ok_ff) begin
               for (int c = 0; c < 3; c++) begin
                  sprod_in[c] = 32'($signed(val_c[c]) * $signed(cmd_ff.amount));
               end
               state_in = S_SUM;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SUM: begin
            // floor((v*amount + 2^13) / 2^14), then saturating add
            for (int c = 0; c < 3; c++) begin
               rnd = $signed({sprod_ff[c][31], sprod_ff[c]}) + 33'sd8192;
               sum = $signed({{3{pose_c[c][15]}}, pose_c[c]}) + 19'(rnd >>> 14);
               if (sum > 19'sd32767) begin
                  sum_c[c] = 16'h7FFF;
               end else if (sum < -19'sd32768) begin
                  sum_c[c] = 16'h8000;
               end else begin
                  sum_c[c] = sum[15:0];
               end
            end
            pose_we   = 1'b1;
            pose_wr.x = sum_c[0];
            pose_wr.y = sum_c[1];
            pose_wr.a = sum_c[2];
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.out_part   = part_ff;
               rsp_in.pose_time  = pose_ff[part_ff].t;
               rsp_in.pose_x     = pose_ff[part_ff].x;
               rsp_in.pose_y     = pose_ff[part_ff].y;
               rsp_in.pose_angle = pose_ff[part_ff].a;
               rsp_in.last_part  = (part_ff == 2'd3);
               part_in           = part_ff + 2'd1;
               state_in          = (part_ff == 2'd3) ? S_IDLE : S_CNT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int p = 0; p < NUM_PARTS; p++) begin
            pose_ff[p] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pose_we) begin
            pose_ff[part_ff] <= pose_wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      part_ff   <= part_in;
      fr_ff     <= fr_in;
      cnt_ff    <= cnt_in;
      single_ff <= single_in;
      prev_ff   <= prev_in;
      span_ff   <= span_in;
      d_ff      <= d_in;
      step_ff   <= step_in;
      neg_ff    <= neg_in;
      base_ff   <= base_in;
      mag_ff    <= mag_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      sprod_ff  <= sprod_in;
      val_ff    <= val_in;
      ok_ff     <= ok_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/keyframe_pose_interpolator.sv =====
// ----------------------------------------------------------------------------
// keyframe_pose_interpolator
// Keyframe table with linear blending into a four-part pose.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command item (load keyframe, set pose, add scaled
//   animation) with valid/ready; unused mode codes are accepted and dropped.
//   rsp_* returns four items per set/add command, parts 0..3 in order, with
//   last_part on the fourth. Loads return nothing.
//   A two-entry command queue sits between the decoder and the executor, so
//   up to two requests are taken while the executor works or rsp is stalled.
//   Load: written from the executor's idle state.
//   Set/add: take the command, then per part the count read, a read
//   and check per keyframe scanned (single-port keyframe RAM), then the
//   blend (multiply plus a 16-step shared-divisor divider on x, y
//   and angle), the pose update and the registered result.
//   A stalled rsp holds the executor in its output step; nothing is lost.
//   Reset clears the frame counts and the pose; keyframe RAM is unset.
// ----------------------------------------------------------------------------
module keyframe_pose_interpolator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kpi_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kpi_pkg::rsp_item_type rsp_data
);
   import kpi_pkg::*;

   q_ctl_type q_ctl;
   cmd_type   push_data, pop_data;
   logic      q_full, pop_valid, pop;

   kpi_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_ctl     (q_ctl),
      .q_data    (push_data)
   );

   kpi_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_ctl     (q_ctl),
      .push_data (push_data),
      .full      (q_full),
      .pop_valid (pop_valid),
      .pop       (pop),
      .pop_data  (pop_data)
   );

   kpi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_pop   (pop),
      .cmd_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/kpi_checker.sv =====
// ----------------------------------------------------------------------------
// kpi_checker
// Watches both channels of the keyframe pose interpolator, keeps its own copy
// of the keyframe table, the frame counts and the pose, and compares every
// returned part item with the predicted one, oldest first.
// ----------------------------------------------------------------------------
module kpi_checker
   import kpi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_item_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_item_type rsp_data,
   output int           fail_count,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   kf_type       key_mem [KF_DEPTH];
   logic [3:0]   count_mem [SEQ_DEPTH];
   kf_type       pose [NUM_PARTS];
   rsp_item_type part_queue [$];

   function automatic logic signed [15:0] blend(logic signed [15:0] a, logic signed [15:0] b,
                                                 longint d, longint span);
      longint diff;
      longint mag;
      longint q;
      diff = longint'(b) - longint'(a);
      mag  = (diff < 0) ? -diff : diff;
      if (span == 0) return a;
      q = (mag * d + span / 2) / span;
      return (diff < 0) ? 16'(longint'(a) - q) : 16'(longint'(a) + q);
   endfunction

   function automatic logic signed [15:0] add_weighted(logic signed [15:0] p,
                                                        logic signed [15:0] v,
                                                        logic signed [15:0] amt);
      longint prod;
      longint sum;
      prod = longint'(v) * longint'(amt);
      sum  = longint'(p) + ((prod + 8192) >>> 14);
      if (sum > 32767) return 16'sh7fff;
      if (sum < -32768) return 16'sh8000;
      return 16'(sum);
   endfunction

   // false when no keyframe pair brackets the time
   function automatic bit eval_part(int anim, int part, logic [15:0] t, output kf_type v);
      int cnt;
      int base;
      kf_type f1;
      kf_type f2;
      v    = '0;
      base = (anim * NUM_PARTS + part) * MAX_FRAMES;
      cnt  = count_mem[anim * NUM_PARTS + part];
      if (anim >= NUM_ANIMS || cnt == 0) return 1;
      if (cnt == 1) begin
         v = key_mem[base];
         return 1;
      end
      for (int i = 1; i < cnt && i < MAX_FRAMES; i++) begin
         f1 = key_mem[base + i - 1];
         f2 = key_mem[base + i];
         if (f1.t <= t && f2.t >= t) begin
            v.t = t;
            v.x = blend(f1.x, f2.x, t - f1.t, f2.t - f1.t);
            v.y = blend(f1.y, f2.y, t - f1.t, f2.t - f1.t);
            v.a = blend(f1.a, f2.a, t - f1.t, f2.t - f1.t);
            return 1;
         end
      end
      return 0;
   endfunction

   task automatic predict_item(req_item_type r);
      kf_type       v;
      bit           hit;
      rsp_item_type e;
      int           seq;
      if (r.mode == MODE_LOAD) begin
         seq = r.anim_index * NUM_PARTS + r.part_index;
         if (r.anim_index < NUM_ANIMS) begin
            if (r.frame_index < MAX_FRAMES)
               key_mem[seq * MAX_FRAMES + r.frame_index] =
                  '{r.key_time, r.key_x, r.key_y, r.key_angle};
            count_mem[seq] = (r.frame_count > MAX_FRAMES) ? 4'(MAX_FRAMES) : r.frame_count;
         end
      end else if (r.mode == MODE_SET || r.mode == MODE_ADD) begin
         for (int k = 0; k < NUM_PARTS; k++) begin
            hit = eval_part(r.anim_index, k, r.eval_time, v);
            if (hit && r.mode == MODE_SET) pose[k] = v;
            else if (hit) begin
               pose[k].x = add_weighted(pose[k].x, v.x, r.amount);
               pose[k].y = add_weighted(pose[k].y, v.y, r.amount);
               pose[k].a = add_weighted(pose[k].a, v.a, r.amount);
            end
            e.out_part   = 2'(k);
            e.pose_time  = pose[k].t;
            e.pose_x     = pose[k].x;
            e.pose_y     = pose[k].y;
            e.pose_angle = pose[k].a;
            e.last_part  = (k == NUM_PARTS - 1);
            part_queue.push_back(e);
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type e;
      if (reset) begin
         fail_count <= 0;
         for (int i = 0; i < SEQ_DEPTH; i++) count_mem[i] = '0;
         for (int i = 0; i < NUM_PARTS; i++) pose[i] = '0;
         part_queue.delete();
      end else begin
         if (req_valid && req_ready) predict_item(req_data);
         if (rsp_valid && rsp_ready) begin
            if (part_queue.size() == 0) begin
               $display("%0t: unexpected part item %p", $realtime, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = part_queue.pop_front();
               if (e !== rsp_data) begin
                  $display("%0t: part item mismatch expected %p actual %p",
                           $realtime, e, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= part_queue.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the keyframe pose interpolator: directed keyframe loads and
// pose updates, then random load/evaluate sequences with random idling on
// both channels and one long response stall. The checker does the compare.
// ----------------------------------------------------------------------------
module tb_top;
   import kpi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam logic [1:0] MODE_NONE = 2'd3;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_ready;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 0;
   rsp_item_type rsp_data;
   int           fail_count;
   int           pending;
   int           cycles = 0;
   int           parts_taken = 0;
   bit           burst = 0;

   // frames written so far, used to keep every evaluated keyframe defined
   bit           written [SEQ_DEPTH][MAX_FRAMES];

   always #2 clock = ~clock;

   keyframe_pose_interpolator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   kpi_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[keyframe_pose_interpolator] ERROR");
         $finish;
      end
   end

   // receiver: random wait per item, one long hold-off after some traffic
   initial begin
      int w;
      bit held = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         w = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
         if (!held && parts_taken >= 40) begin
            w = 400;
            held = 1;
         end
         if (w > 0) begin
            rsp_ready <= 0;
            repeat (w) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         parts_taken++;
         @(negedge clock);
      end
   end

   task automatic drive(req_item_type r);
      int gap;
      gap = burst ? 0 : $urandom_range(12);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // clamps a load count to the defined prefix of its sequence
   task automatic issue(req_item_type r);
      int seq;
      int prefix;
      int cnt;
      if (r.mode == MODE_LOAD) begin
         seq = r.anim_index * NUM_PARTS + r.part_index;
         written[seq][r.frame_index] = 1;
         prefix = 0;
         while (prefix < MAX_FRAMES && written[seq][prefix]) prefix++;
         cnt = (r.frame_count > MAX_FRAMES) ? MAX_FRAMES : r.frame_count;
         if (cnt > prefix) r.frame_count = 4'(prefix);
      end
      drive(r);
   endtask

   function automatic req_item_type load_item(int anim, int part, int frame, int cnt,
                                              logic [15:0] t, logic [15:0] x,
                                              logic [15:0] y, logic [15:0] a);
      req_item_type r;
      r = req_item_type'({$urandom, $urandom, $urandom});
      r.mode = MODE_LOAD;
      r.anim_index = 4'(anim);
      r.part_index = 2'(part);
      r.frame_index = 3'(frame);
      r.frame_count = 4'(cnt);
      r.key_time = t;
      r.key_x = x;
      r.key_y = y;
      r.key_angle = a;
      return r;
   endfunction

   function automatic req_item_type pose_item(logic [1:0] mode, int anim,
                                              logic [15:0] t, logic [15:0] amt);
      req_item_type r;
      r = req_item_type'({$urandom, $urandom, $urandom});
      r.mode = mode;
      r.anim_index = 4'(anim);
      r.eval_time = t;
      r.amount = amt;
      return r;
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int items;
      int anim;
      int part;
      int n;
      int cnt;
      logic [15:0] t;
      logic [15:0] t_first;
      req_item_type r;

      for (int s = 0; s < SEQ_DEPTH; s++)
         for (int f = 0; f < MAX_FRAMES; f++) written[s][f] = 0;
      repeat (3) @(negedge clock);
      reset <= 0;

      // directed: segments, zero-length segment, single frame, empty part
      issue(load_item(0, 0, 0, 3, 16'h1000, 16'h7fff, 16'h8000, 16'h0100));
      issue(load_item(0, 0, 1, 3, 16'h1000, 16'h0000, 16'h7fff, 16'h8000));
      issue(load_item(0, 0, 2, 3, 16'h3000, 16'h8000, 16'h0001, 16'h7fff));
      issue(load_item(0, 1, 0, 1, 16'hffff, 16'h1234, 16'hfedc, 16'h8000));
      issue(load_item(0, 3, 0, 2, 16'h0000, 16'h8000, 16'h8000, 16'h8000));
      issue(load_item(0, 3, 1, 2, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff));
      issue(pose_item(MODE_SET, 0, 16'h1000, 16'h0000));
      issue(pose_item(MODE_SET, 0, 16'h2000, 16'h0000));
      issue(pose_item(MODE_SET, 0, 16'h0800, 16'h0000));
      issue(pose_item(MODE_SET, 0, 16'hffff, 16'h0000));
      issue(pose_item(MODE_SET, 0, 16'h0000, 16'h0000));
      issue(pose_item(MODE_ADD, 0, 16'h1800, 16'h7fff));
      issue(pose_item(MODE_ADD, 0, 16'h1800, 16'h7fff));
      issue(pose_item(MODE_ADD, 0, 16'h3000, 16'h8000));
      issue(pose_item(MODE_ADD, 0, 16'h3000, 16'h8000));
      issue(pose_item(MODE_ADD, 0, 16'h3000, 16'h8000));
      issue(pose_item(MODE_ADD, 0, 16'h2000, 16'h0000));
      issue(pose_item(MODE_ADD, 0, 16'h4000, 16'h4000));
      issue(pose_item(MODE_NONE, 0, 16'h1000, 16'h4000));
      issue(load_item(0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
      issue(pose_item(MODE_SET, 0, 16'h1000, 16'h0000));
      issue(pose_item(MODE_SET, 15, 16'h1000, 16'h0000));

      items = 0;
      while (items < 160) begin
         burst = ($urandom_range(4) == 0);
         if ($urandom_range(9) < 7) begin
            // well-formed sequence with random content, then evaluations
            anim = $urandom_range(NUM_ANIMS - 1);
            part = $urandom_range(NUM_PARTS - 1);
            n = ($urandom_range(5) == 0) ? MAX_FRAMES : $urandom_range(1, 4);
            cnt = (n == MAX_FRAMES && $urandom_range(1)) ? $urandom_range(9, 15) : n;
            t = 16'($urandom_range(16'h4000));
            t_first = t;
            for (int f = 0; f < n; f++) begin
               issue(load_item(anim, part, f, cnt, t, pick16(), pick16(), pick16()));
               items++;
               if (f < n - 1 && $urandom_range(4) != 0) t = t + 16'($urandom_range(16'h1800));
            end
            repeat ($urandom_range(1, 3)) begin
               r = pose_item($urandom_range(1) ? MODE_SET : MODE_ADD, anim,
                             ($urandom_range(3) == 0) ? pick16() :
                             16'(t_first + $urandom_range(t - t_first)), pick16());
               issue(r);
               items++;
            end
         end else begin
            r = req_item_type'({$urandom, $urandom, $urandom, $urandom});
            issue(r);
            if (r.mode != MODE_NONE) items++;
         end
      end

      burst = 0;
      @(negedge clock);
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0)
         $display("[keyframe_pose_interpolator] OK");
      else
         $display("[keyframe_pose_interpolator] ERROR");
      $finish;
   end

endmodule
